// ===== src/okrt_pkg.sv =====
// ----------------------------------------------------------------------------
// okrt_pkg
// Types and codes shared by the ordered keyed record table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package okrt_pkg;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_UPDATE = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_EMPTY     = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] item_key;
		logic [19:0] item_quantity;
		logic [23:0] item_price;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] record_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] key;
		logic [19:0] quantity;
		logic [23:0] price;
	} rec_t;

	typedef struct packed {
		logic start;
		logic step;
		logic add_en;
		logic upd_en;
		logic rm_en;
		rec_t wdata;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/okrt_cell.sv =====
// ----------------------------------------------------------------------------
// okrt_cell
// One table slot: holds a record, passes the search token to its neighbour
// and takes the neighbour's record when a removal closes the gap.
// ----------------------------------------------------------------------------
`default_nettype none

module okrt_cell #(
	parameter int CNT_W = 5,
	parameter int INDEX = 0
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire okrt_pkg::cell_ctl_t ctl,
	input  wire [CNT_W-1:0]       count,
	input  wire                   tok_in,
	input  wire okrt_pkg::rec_t   next_rec,
	output logic                  tok_out,
	output okrt_pkg::rec_t        rec_out,
	output logic                  hit,
	output logic                  miss
);
	import okrt_pkg::*;

	logic tok_q;
	logic passed_q;
	rec_t rec_q;
	logic in_range;

	assign in_range = count > CNT_W'(INDEX);
	assign hit      = tok_q & in_range & (rec_q.key == ctl.wdata.key);
	assign miss     = tok_q & ~in_range;
	assign tok_out  = tok_q;
	assign rec_out  = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= 1'b0;
			passed_q <= 1'b0;
		end else if (ctl.start) begin
			tok_q    <= (INDEX == 0);
			passed_q <= 1'b0;
		end else if (ctl.step) begin
			tok_q    <= tok_in;
			passed_q <= passed_q | tok_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add_en && (count == CNT_W'(INDEX))) begin
			rec_q <= ctl.wdata;
		end else if (ctl.upd_en && tok_q) begin
			rec_q.quantity <= ctl.wdata.quantity;
			rec_q.price    <= ctl.wdata.price;
		end else if (ctl.rm_en && !passed_q) begin
			rec_q <= next_rec;
		end
	end

endmodule

`default_nettype wire

// ===== src/ordered_keyed_record_table.sv =====
// ----------------------------------------------------------------------------
// ordered_keyed_record_table
// Ordered table of key, quantity and price records with add at tail, update
// of the first match and removal of the first match keeping the order.
// ----------------------------------------------------------------------------
// response: add, unused code and remove on empty table answer at the accept
//   edge; update and remove answer once the search token, walking the cell
//   chain slot by slot, hits a match or passes the last record
// throughput: one transaction at a time, the next accepted once the result
//   is out; removal shifts all later cells in the cycle the match is found
// reset: record count cleared, stored records undefined until written
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_keyed_record_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_stall,
	input  wire okrt_pkg::req_t req,
	output logic            rsp_valid,
	input  wire             rsp_stall,
	output okrt_pkg::rsp_t  rsp
);
	import okrt_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_SEARCH
	} state_t;

	state_t          state_q;
	req_t            req_q;
	logic [CNT_W-1:0] count_q;
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	cell_ctl_t        ctl;
	rec_t             rec_w [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] tok_w;
	logic [TABLE_DEPTH-1:0] hit_w;
	logic [TABLE_DEPTH-1:0] miss_w;

	logic accept;
	logic full;
	logic needs_search;
	logic any_hit;
	logic finish;

	assign req_stall    = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept       = req_valid && !req_stall;
	assign full         = count_q >= CNT_W'(TABLE_DEPTH);
	assign needs_search = (req.req_type == REQ_UPDATE) ||
	                      ((req.req_type == REQ_REMOVE) && (count_q != '0));
	assign any_hit      = |hit_w;
	assign finish       = (state_q == S_SEARCH) && (any_hit || (|miss_w) || !(|tok_w));

	always_comb begin
		ctl.start  = accept && needs_search;
		ctl.step   = state_q == S_SEARCH;
		ctl.add_en = accept && (req.req_type == REQ_ADD) && !full;
		ctl.upd_en = (state_q == S_SEARCH) && any_hit && (req_q.req_type == REQ_UPDATE);
		ctl.rm_en  = (state_q == S_SEARCH) && any_hit && (req_q.req_type == REQ_REMOVE);
		if (state_q == S_IDLE) begin
			ctl.wdata.key      = req.item_key;
			ctl.wdata.quantity = req.item_quantity;
			ctl.wdata.price    = req.item_price;
		end else begin
			ctl.wdata.key      = req_q.item_key;
			ctl.wdata.quantity = req_q.item_quantity;
			ctl.wdata.price    = req_q.item_price;
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic tok_in;
		rec_t next_rec;
		if (i == 0) begin : g_first
			assign tok_in = 1'b0;
		end else begin : g_inner
			assign tok_in = tok_w[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_last
			assign next_rec = rec_w[i];
		end else begin : g_mid
			assign next_rec = rec_w[i+1];
		end
		okrt_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.count    (count_q),
			.tok_in   (tok_in),
			.next_rec (next_rec),
			.tok_out  (tok_w[i]),
			.rec_out  (rec_w[i]),
			.hit      (hit_w[i]),
			.miss     (miss_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			req_q       <= '0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= req;
						if (needs_search) begin
							state_q <= S_SEARCH;
						end else begin
							rsp_valid_q <= 1'b1;
							case (req.req_type)
								REQ_ADD: begin
									if (full) begin
										rsp_q.status       <= STAT_FULL;
										rsp_q.record_count <= 5'(count_q);
									end else begin
										rsp_q.status       <= STAT_DONE;
										rsp_q.record_count <= 5'(count_q + 1'b1);
										count_q            <= count_q + 1'b1;
									end
								end
								REQ_REMOVE: begin
									rsp_q.status       <= STAT_EMPTY;
									rsp_q.record_count <= 5'(count_q);
								end
								default: begin
									rsp_q.status       <= STAT_DONE;
									rsp_q.record_count <= 5'(count_q);
								end
							endcase
						end
					end
				end
				S_SEARCH: begin
					if (finish) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b1;
						if (!any_hit) begin
							rsp_q.status       <= STAT_NOT_FOUND;
							rsp_q.record_count <= 5'(count_q);
						end else if (req_q.req_type == REQ_REMOVE) begin
							rsp_q.status       <= STAT_DONE;
							rsp_q.record_count <= 5'(count_q - 1'b1);
							count_q            <= count_q - 1'b1;
						end else begin
							rsp_q.status       <= STAT_DONE;
							rsp_q.record_count <= 5'(count_q);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== tb/ordered_keyed_record_table_test.sv =====
// ----------------------------------------------------------------------------
// ordered_keyed_record_table_test
// Self-checking bench for the ordered keyed record table. A directed table of
// requests covers empty, full, no-match, duplicate-key and unused-code cases,
// then random phases swing the table between full and empty using keys drawn
// half the time from the records held. Each result is checked against its
// directed row or a local table model, with random idling on both channels,
// a long receiver hold-off and sender pauses until all results are back.
// ----------------------------------------------------------------------------

module ordered_keyed_record_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	import okrt_pkg::*;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 300;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 92;
	localparam int TAIL_CYCLES = 40;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// shadow copy of the table
	logic [15:0] tbl_key [DEPTH];
	logic [19:0] tbl_qty [DEPTH];
	logic [23:0] tbl_price [DEPTH];
	int held = 0;

	rsp_t want_q [$];
	row_t rows [$];

	bit   cur_typed = 1'b0;
	rsp_t cur_want = '0;
	bit   quiet = 1'b0;
	bit   hold_req = 1'b0;
	int   hold_left = 0;
	int   rsp_wait = 0;
	int   errors = 0;
	int   cycles = 0;

	ordered_keyed_record_table #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	task automatic report_error(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	function automatic int find_key(input logic [15:0] k);
		for (int i = 0; i < held; i++) begin
			if (tbl_key[i] == k) return i;
		end
		return -1;
	endfunction

	function automatic rsp_t table_apply(input req_t r);
		rsp_t o;
		int pos;
		o.status = STAT_DONE;
		case (r.req_type)
			REQ_ADD: begin
				if (held >= DEPTH) begin
					o.status = STAT_FULL;
				end else begin
					tbl_key[held] = r.item_key;
					tbl_qty[held] = r.item_quantity;
					tbl_price[held] = r.item_price;
					held++;
				end
			end
			REQ_UPDATE: begin
				pos = find_key(r.item_key);
				if (pos < 0) begin
					o.status = STAT_NOT_FOUND;
				end else begin
					tbl_qty[pos] = r.item_quantity;
					tbl_price[pos] = r.item_price;
				end
			end
			REQ_REMOVE: begin
				if (held == 0) begin
					o.status = STAT_EMPTY;
				end else begin
					pos = find_key(r.item_key);
					if (pos < 0) begin
						o.status = STAT_NOT_FOUND;
					end else begin
						for (int i = pos; i < held - 1; i++) begin
							tbl_key[i] = tbl_key[i + 1];
							tbl_qty[i] = tbl_qty[i + 1];
							tbl_price[i] = tbl_price[i + 1];
						end
						held--;
					end
				end
			end
			default: begin
			end
		endcase
		o.record_count = 5'(held);
		return o;
	endfunction

	function automatic req_t random_item(input int add_w);
		req_t r;
		int roll;
		int ksel;
		roll = $urandom_range(0, 99);
		if (roll < 2) r.req_type = REQ_UNUSED;
		else if (roll < 2 + add_w) r.req_type = REQ_ADD;
		else if ($urandom_range(0, 2) == 0) r.req_type = REQ_UPDATE;
		else r.req_type = REQ_REMOVE;
		ksel = $urandom_range(0, 9);
		if (ksel < 5 && held > 0) begin
			r.item_key = tbl_key[$urandom_range(0, held - 1)];
		end else if (ksel < 8) begin
			case ($urandom_range(0, 3))
				0: r.item_key = 16'h0000;
				1: r.item_key = 16'hFFFF;
				2: r.item_key = 16'h5A5A;
				default: r.item_key = 16'hA5A5;
			endcase
		end else begin
			r.item_key = 16'($urandom);
		end
		case ($urandom_range(0, 9))
			0: r.item_quantity = '0;
			1: r.item_quantity = '1;
			default: r.item_quantity = 20'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: r.item_price = '0;
			1: r.item_price = '1;
			default: r.item_price = 24'($urandom);
		endcase
		return r;
	endfunction

	function void add_row(input logic [1:0] op, input logic [15:0] k, input logic [19:0] q,
		input logic [23:0] p, input bit typed, input logic [1:0] st, input int cnt);
		row_t row;
		row.item.req_type = op;
		row.item.item_key = k;
		row.item.item_quantity = q;
		row.item.item_price = p;
		row.typed = typed;
		row.want.status = st;
		row.want.record_count = 5'(cnt);
		rows.push_back(row);
	endfunction

	// offer one transaction after a random gap and wait until it is taken
	task automatic offer(input bit from_row, input int sel, output logic [1:0] op);
		int gap;
		req_t r;
		gap = quiet ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (from_row) begin
			r = rows[sel].item;
			cur_typed = rows[sel].typed;
			cur_want = rows[sel].want;
		end else begin
			r = random_item(sel);
			cur_typed = 1'b0;
		end
		req <= r;
		req_valid <= 1'b1;
		op = r.req_type;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin : monitor
		rsp_t exp_rsp;
		if (req_valid && !req_stall) begin
			exp_rsp = table_apply(req);
			want_q.push_back(cur_typed ? cur_want : exp_rsp);
		end
		if (rsp_valid && !rsp_stall) begin
			rsp_wait = quiet ? 0 : $urandom_range(0, 4);
			if (want_q.size() == 0) begin
				report_error($sformatf("result with nothing pending: status %0d count %0d",
					rsp.status, rsp.record_count));
			end else begin
				exp_rsp = want_q.pop_front();
				if (rsp.status !== exp_rsp.status)
					report_error($sformatf("status %0d, wanted %0d",
						rsp.status, exp_rsp.status));
				if (rsp.record_count !== exp_rsp.record_count)
					report_error($sformatf("record_count %0d, wanted %0d",
						rsp.record_count, exp_rsp.record_count));
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (rsp_wait > 0) begin
			rsp_wait--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("ordered_keyed_record_table_test: errors");
			$finish;
		end
	end

	initial begin : stimulus
		logic [1:0] op;
		int counted;
		int add_w;

		add_row(REQ_REMOVE, 16'h0000, '1, '1, 1'b1, STAT_EMPTY, 0);
		add_row(REQ_UPDATE, 16'hFFFF, '1, '1, 1'b1, STAT_NOT_FOUND, 0);
		add_row(REQ_UNUSED, '1, '1, '1, 1'b1, STAT_DONE, 0);
		add_row(REQ_ADD, 16'h0000, '0, '0, 1'b1, STAT_DONE, 1);
		add_row(REQ_ADD, 16'hFFFF, '1, '1, 1'b1, STAT_DONE, 2);
		add_row(REQ_ADD, 16'h0000, 20'd12345, 24'd999999, 1'b1, STAT_DONE, 3);
		add_row(REQ_UPDATE, 16'hFFFF, '0, '0, 1'b0, STAT_DONE, 0);
		add_row(REQ_UPDATE, 16'h0000, '1, '1, 1'b0, STAT_DONE, 0);
		add_row(REQ_UPDATE, 16'h1234, '1, '0, 1'b1, STAT_NOT_FOUND, 3);
		add_row(REQ_REMOVE, 16'h1234, '1, '1, 1'b1, STAT_NOT_FOUND, 3);
		add_row(REQ_REMOVE, 16'h0000, '0, '0, 1'b0, STAT_DONE, 0);
		for (int i = 0; i < DEPTH - 2; i++)
			add_row(REQ_ADD, 16'h0100 + 16'(i), (i % 2) ? '1 : '0, (i % 2) ? '0 : '1,
				1'b0, STAT_DONE, 0);
		add_row(REQ_ADD, 16'hBEEF, '1, '1, 1'b1, STAT_FULL, DEPTH);
		add_row(REQ_REMOVE, 16'h0100 + 16'(DEPTH - 3), '0, '0, 1'b0, STAT_DONE, 0);
		add_row(REQ_REMOVE, 16'hFFFF, '0, '0, 1'b0, STAT_DONE, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) offer(1'b1, i, op);
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			quiet = (ph % 4 == 2);
			if (ph == 3 || ph == 8) hold_req = 1'b1;
			case (ph % 3)
				0: add_w = 70;
				1: add_w = 10;
				default: add_w = 45;
			endcase
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				offer(1'b0, add_w, op);
				if (op != REQ_UNUSED) counted++;
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ordered_keyed_record_table_test: clean");
		else
			$display("ordered_keyed_record_table_test: errors");
		$finish;
	end

endmodule

// ===== files.f =====
src/okrt_pkg.sv
src/okrt_cell.sv
src/ordered_keyed_record_table.sv
tb/ordered_keyed_record_table_test.sv
